[design/assert_macros.svh]
// Assertion macros shared by the table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[design/kst_pkg.sv]
package kst_pkg;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned SLOT_OUT_W = 4;

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_STORE = 2'd1,
    OP_TAKE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_COMMIT,
    ST_RESPOND
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture the input word
    logic compare;  // register match / free vectors
    logic resolve;  // priority encode, register hit and slot
    logic commit;   // update table, read values
  } ctrl_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] feature;
    logic [VAL_W-1:0] query;
    logic [VAL_W-1:0] plan;
  } value_t;

endpackage

[design/kst_ctrl.sv]
`include "assert_macros.svh"

module kst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output kst_pkg::ctrl_cmd_t   cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import kst_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    accept  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        accept = start_i;
      end
      ST_MATCH: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_RESPOND;
      end
      ST_RESPOND: begin
        // result on the ports; next word may be taken in the same cycle
        busy_o  = 1'b0;
        done_o  = 1'b1;
        accept  = start_i;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (accept) begin
      cmd_o.load = 1'b1;
      state_d    = ST_MATCH;
    end
  end

  `ASSERT_AT(a_accept_to_match, clk_i, rst_ni, start_i && !busy_o |=> state_q == ST_MATCH,
             "accepted word did not enter compare")
  `ASSERT_AT(a_respond_after_commit, clk_i, rst_ni, done_o |-> $past(cmd_o.commit),
             "result strobe without a preceding commit")
  `ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_o && busy_o,
                "result strobe while busy")

endmodule

[design/kst_datapath.sv]
`include "assert_macros.svh"

module kst_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kst_pkg::ctrl_cmd_t                   cmd_i,
  input  logic [1:0]                           operation_i,
  input  logic [kst_pkg::KEY_W-1:0]            lookup_key_i,
  input  logic                                 allocate_if_absent_i,
  input  logic [kst_pkg::VAL_W-1:0]            feature_value_i,
  input  logic [kst_pkg::VAL_W-1:0]            query_value_i,
  input  logic [kst_pkg::VAL_W-1:0]            plan_value_i,
  output logic                                 hit_o,
  output logic [kst_pkg::SLOT_OUT_W-1:0]       slot_index_o,
  output logic [kst_pkg::VAL_W-1:0]            feature_result_o,
  output logic [kst_pkg::VAL_W-1:0]            query_result_o,
  output logic [kst_pkg::VAL_W-1:0]            plan_result_o
);
  import kst_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // captured word
  op_e              op_q;
  logic [KEY_W-1:0] key_q;
  logic             alloc_q;
  value_t           wval_q;

  // table: valid bits and keys in flops (parallel compare), values in memory
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [KEY_W-1:0]         key_tab_q [TABLE_ENTRIES];
  value_t                   val_mem [TABLE_ENTRIES];
  value_t                   rdata_q;

  logic [TABLE_ENTRIES-1:0] match_q, free_q;
  logic                     hit_q, hit_d;
  logic [IDX_W-1:0]         slot_q, slot_d;
  logic [IDX_W-1:0]         match_idx, free_idx;
  logic                     match_any, free_any;
  logic                     take_hit;
  logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q           <= op_e'(operation_i);
      key_q          <= lookup_key_i;
      alloc_q        <= allocate_if_absent_i;
      wval_q.feature <= feature_value_i;
      wval_q.query   <= query_value_i;
      wval_q.plan    <= plan_value_i;
    end
  end

  // compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      free_q  <= '0;
    end else if (cmd_i.compare) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        match_q[i] <= valid_q[i] && (key_tab_q[i] == key_q);
        free_q[i]  <= !valid_q[i];
      end
    end
  end

  // lowest set bit wins
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) match_idx = IDX_W'(i);
      if (free_q[i])  free_idx  = IDX_W'(i);
    end
    match_any = |match_q;
    free_any  = |free_q;
  end

  always_comb begin
    hit_d  = 1'b0;
    slot_d = '0;
    unique case (op_q)
      OP_FIND: begin
        if (match_any) begin
          hit_d  = 1'b1;
          slot_d = match_idx;
        end else if (alloc_q && free_any) begin
          hit_d  = 1'b1;
          slot_d = free_idx;
        end
      end
      OP_STORE: begin
        hit_d = 1'b1;
        if (match_any) begin
          slot_d = match_idx;
        end else if (free_any) begin
          slot_d = free_idx;
        end
      end
      OP_TAKE: begin
        if (match_any) begin
          hit_d  = 1'b1;
          slot_d = match_idx;
        end
      end
      OP_CLEAR: begin
        hit_d  = 1'b0;
        slot_d = '0;
      end
      default: begin
        hit_d  = 1'b0;
        slot_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      slot_q <= '0;
    end else if (cmd_i.resolve) begin
      hit_q  <= hit_d;
      slot_q <= slot_d;
    end
  end

  // commit: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      case (op_q)
        OP_STORE: valid_q[slot_q] <= 1'b1;
        OP_TAKE:  if (hit_q) valid_q[slot_q] <= 1'b0;
        OP_CLEAR: valid_q <= '0;
        default:  valid_q <= valid_q;
      endcase
    end
  end

  // keys of invalid entries are masked at compare, so no clear needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && op_q == OP_STORE) begin
      key_tab_q[slot_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (op_q == OP_STORE) begin
        val_mem[slot_q] <= wval_q;
      end
      rdata_q <= val_mem[slot_q];
    end
  end

  assign take_hit         = (op_q == OP_TAKE) && hit_q;
  assign hit_o            = hit_q;
  assign slot_ext         = {{SLOT_OUT_W{1'b0}}, slot_q};
  assign slot_index_o     = slot_ext[SLOT_OUT_W-1:0];
  assign feature_result_o = take_hit ? rdata_q.feature : '0;
  assign query_result_o   = take_hit ? rdata_q.query   : '0;
  assign plan_result_o    = take_hit ? rdata_q.plan    : '0;

  `ASSERT_AT(a_keys_unique, clk_i, rst_ni, $onehot0(match_q),
             "more than one valid entry matches the key")
  `ASSERT_AT(a_miss_slot_zero, clk_i, rst_ni, cmd_i.commit && !hit_q |-> slot_q == '0,
             "slot nonzero on a miss")
  `ASSERT_AT(a_store_sets_valid, clk_i, rst_ni,
             cmd_i.commit && op_q == OP_STORE |=> valid_q[$past(slot_q)],
             "store did not mark its slot valid")

endmodule

[design/keyed_slot_table_find_or_allocate.sv]
// An accepted word passes through the compare, resolve and commit states before done_o.
// One word at a time: start_i is taken again in the done_o cycle, not before.
// Steps: key compare, priority encode, table update / value read, result.
// Reset (async, active low) clears all valid bits, so the table comes up empty.
// Results show for one cycle on done_o; the receiver cannot stall them.
module keyed_slot_table_find_or_allocate #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     operation_i,
  input  logic [kst_pkg::KEY_W-1:0]      lookup_key_i,
  input  logic                           allocate_if_absent_i,
  input  logic [kst_pkg::VAL_W-1:0]      feature_value_i,
  input  logic [kst_pkg::VAL_W-1:0]      query_value_i,
  input  logic [kst_pkg::VAL_W-1:0]      plan_value_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic [kst_pkg::SLOT_OUT_W-1:0] slot_index_o,
  output logic [kst_pkg::VAL_W-1:0]      feature_result_o,
  output logic [kst_pkg::VAL_W-1:0]      query_result_o,
  output logic [kst_pkg::VAL_W-1:0]      plan_result_o
);
  import kst_pkg::*;

  // Controller sequences one word at a time through the datapath steps.
  ctrl_cmd_t cmd;

  kst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Datapath: valid bits and keys in flops for the parallel compare, the
  // three values in a one-port memory read at the resolved slot.
  kst_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .operation_i          (operation_i),
    .lookup_key_i         (lookup_key_i),
    .allocate_if_absent_i (allocate_if_absent_i),
    .feature_value_i      (feature_value_i),
    .query_value_i        (query_value_i),
    .plan_value_i         (plan_value_i),
    .hit_o                (hit_o),
    .slot_index_o         (slot_index_o),
    .feature_result_o     (feature_result_o),
    .query_result_o       (query_result_o),
    .plan_result_o        (plan_result_o)
  );

endmodule

[verif/keyed_slot_table_find_or_allocate_test.sv]
`timescale 1ns / 100ps

module keyed_slot_table_find_or_allocate_test;
  import kst_pkg::*;

  localparam int SLOTS       = 16;
  localparam int STALL_LIMIT = 256;
  localparam int TAIL_WORDS  = 300;  // final words go in back to back
  localparam int SEGMENTS    = 20;
  localparam int SEG_WORDS   = 100;
  localparam int POOL_MAX    = 48;

  // One command word as presented on the input ports.
  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic             alloc;
    logic [VAL_W-1:0] feature;
    logic [VAL_W-1:0] query;
    logic [VAL_W-1:0] plan;
  } word_t;

  // One result word as seen on the output ports while done_o is high.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [VAL_W-1:0]      feature;
    logic [VAL_W-1:0]      query;
    logic [VAL_W-1:0]      plan;
  } outcome_t;

  logic                  clk_i                = 1'b0;
  logic                  rst_ni               = 1'b0;
  logic                  start_i              = 1'b0;
  logic [1:0]            operation_i          = '0;
  logic [KEY_W-1:0]      lookup_key_i         = '0;
  logic                  allocate_if_absent_i = 1'b0;
  logic [VAL_W-1:0]      feature_value_i      = '0;
  logic [VAL_W-1:0]      query_value_i        = '0;
  logic [VAL_W-1:0]      plan_value_i         = '0;
  logic                  busy_o;
  logic                  done_o;
  logic                  hit_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;
  logic [VAL_W-1:0]      feature_result_o;
  logic [VAL_W-1:0]      query_result_o;
  logic [VAL_W-1:0]      plan_result_o;

  // Shadow copy of the table, updated in acceptance order.
  logic             slot_valid   [SLOTS] = '{default: 1'b0};
  logic [KEY_W-1:0] slot_key     [SLOTS] = '{default: '0};
  logic [VAL_W-1:0] slot_feature [SLOTS] = '{default: '0};
  logic [VAL_W-1:0] slot_query   [SLOTS] = '{default: '0};
  logic [VAL_W-1:0] slot_plan    [SLOTS] = '{default: '0};

  word_t    pending_words[$];   // words not yet presented
  outcome_t expected_q[$];      // outcomes of accepted words, oldest first
  word_t    cur_word     = '0;  // word currently on the input ports
  int       total_words  = 0;
  int       issued_cnt   = 0;
  int       accepted_cnt = 0;
  int       gap_left     = 0;
  int       stall_cycles = 0;
  int       errors       = 0;

  always #4 clk_i = ~clk_i;

  keyed_slot_table_find_or_allocate #(
    .TABLE_ENTRIES(SLOTS)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .operation_i         (operation_i),
    .lookup_key_i        (lookup_key_i),
    .allocate_if_absent_i(allocate_if_absent_i),
    .feature_value_i     (feature_value_i),
    .query_value_i       (query_value_i),
    .plan_value_i        (plan_value_i),
    .done_o              (done_o),
    .hit_o               (hit_o),
    .slot_index_o        (slot_index_o),
    .feature_result_o    (feature_result_o),
    .query_result_o      (query_result_o),
    .plan_result_o       (plan_result_o)
  );

  // Applies one word to the shadow table and returns the result it must give.
  // Lowest valid slot with an equal key wins; lowest invalid slot is the free one.
  function automatic outcome_t table_outcome(word_t w);
    outcome_t r;
    int       hit_at;
    int       free_at;
    int       s;
    r       = '0;
    hit_at  = -1;
    free_at = -1;
    s       = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_at < 0 && slot_valid[i] && slot_key[i] == w.key) hit_at = i;
      if (free_at < 0 && !slot_valid[i]) free_at = i;
    end
    case (w.op)
      OP_FIND: begin
        // a miss with allocation only reports the free slot, it does not claim it
        if (hit_at >= 0) begin
          r.hit = 1'b1;
          s     = hit_at;
        end else if (w.alloc && free_at >= 0) begin
          r.hit = 1'b1;
          s     = free_at;
        end
      end
      OP_STORE: begin
        // match, else first free, else slot 0 gets overwritten
        s = (hit_at >= 0) ? hit_at : ((free_at >= 0) ? free_at : 0);
        slot_valid[s]   = 1'b1;
        slot_key[s]     = w.key;
        slot_feature[s] = w.feature;
        slot_query[s]   = w.query;
        slot_plan[s]    = w.plan;
        r.hit           = 1'b1;
      end
      OP_TAKE: begin
        if (hit_at >= 0) begin
          s               = hit_at;
          r.hit           = 1'b1;
          r.feature       = slot_feature[s];
          r.query         = slot_query[s];
          r.plan          = slot_plan[s];
          slot_valid[s]   = 1'b0;
          slot_key[s]     = '0;
          slot_feature[s] = '0;
          slot_query[s]   = '0;
          slot_plan[s]    = '0;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_valid[i]   = 1'b0;
          slot_key[i]     = '0;
          slot_feature[i] = '0;
          slot_query[i]   = '0;
          slot_plan[i]    = '0;
        end
      end
    endcase
    if (r.hit) r.slot = s[SLOT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_word(op_e op, logic [KEY_W-1:0] key, logic alloc,
                          logic [VAL_W-1:0] f, logic [VAL_W-1:0] q,
                          logic [VAL_W-1:0] p);
    word_t w;
    w.op      = op;
    w.key     = key;
    w.alloc   = alloc;
    w.feature = f;
    w.query   = q;
    w.plan    = p;
    pending_words.push_back(w);
  endtask

  // Driver: a word is taken at an edge with start_i high and busy_o low.
  // start_i only moves after an acceptance or while it is already low, so it
  // never drops under a waiting word. Idle bursts come at random,
  // except in every third block of 64 words and in the final stretch.
  always @(posedge clk_i) begin : word_driver
    logic  fire;
    word_t w;
    if (rst_ni) begin
      fire = start_i && !busy_o;
      if (fire) begin
        expected_q.push_back(table_outcome(cur_word));
        accepted_cnt++;
      end
      if (fire || !start_i) begin
        if (gap_left != 0) begin
          start_i <= 1'b0;
          gap_left--;
        end else if (pending_words.size() == 0) begin
          start_i <= 1'b0;
        end else if (fire && issued_cnt + TAIL_WORDS < total_words &&
                     ((issued_cnt / 64) % 3) != 2 && $urandom_range(0, 3) == 0) begin
          start_i  <= 1'b0;
          gap_left = $urandom_range(0, 6);
        end else begin
          w = pending_words.pop_front();
          cur_word             <= w;
          operation_i          <= w.op;
          lookup_key_i         <= w.key;
          allocate_if_absent_i <= w.alloc;
          feature_value_i      <= w.feature;
          query_value_i        <= w.query;
          plan_value_i         <= w.plan;
          start_i              <= 1'b1;
          issued_cnt++;
        end
      end
    end
  end

  // Monitor: done_o marks a one-cycle result word; compare with the oldest outcome.
  always @(posedge clk_i) begin : result_monitor
    outcome_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result word with no command outstanding");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit_o);
          errors++;
        end
        if (slot_index_o !== want.slot) begin
          $error("slot_index: expected %0d, actual %0d", want.slot, slot_index_o);
          errors++;
        end
        if (feature_result_o !== want.feature) begin
          $error("feature_result: expected %h, actual %h", want.feature, feature_result_o);
          errors++;
        end
        if (query_result_o !== want.query) begin
          $error("query_result: expected %h, actual %h", want.query, query_result_o);
          errors++;
        end
        if (plan_result_o !== want.plan) begin
          $error("plan_result: expected %h, actual %h", want.plan, plan_result_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without a word going in or coming out means a hang.
  always @(posedge clk_i) begin : stall_watch
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("keyed_slot_table_find_or_allocate: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [POOL_MAX];
    logic [KEY_W-1:0] key;
    int               pool_n;
    int               store_pct;
    int               take_pct;
    int               r;

    // Directed: empty-table misses, key and value extremes, update in place,
    // take and the hole it leaves, filling up, full-table find and overwrite,
    // then clear.
    add_word(OP_FIND,  '0, 1'b0, '0, '0, '0);
    add_word(OP_FIND,  '0, 1'b1, '0, '0, '0);
    add_word(OP_STORE, '0, 1'b0, '1, '1, '1);
    add_word(OP_STORE, '1, 1'b1, '0, '0, '0);
    add_word(OP_STORE, '0, 1'b0, {32{2'b10}}, {32{2'b01}}, rand64());
    add_word(OP_FIND,  '1, 1'b0, '1, '1, '1);
    add_word(OP_TAKE,  '0, 1'b0, '0, '0, '0);
    for (int i = 2; i <= 16; i++) begin
      add_word(OP_STORE, 64'(i), 1'b0, rand64(), rand64(), rand64());
    end
    add_word(OP_FIND,  64'hdead_beef_0000_0001, 1'b1, '0, '0, '0);
    add_word(OP_STORE, 64'hdead_beef_0000_0001, 1'b0, rand64(), rand64(), rand64());
    add_word(OP_TAKE,  64'd16, 1'b0, '0, '0, '0);
    add_word(OP_CLEAR, rand64(), 1'b1, rand64(), rand64(), rand64());
    add_word(OP_TAKE,  '1, 1'b0, '0, '0, '0);

    // Random: each segment draws a key pool and an operation mix. Small pools
    // give many hits, big pools with heavy stores fill the table and force
    // slot 0 overwrites; a tenth of the keys are fresh noise.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 3))
        0: pool_n = 3;
        1: pool_n = 12;
        2: pool_n = 20;
        default: pool_n = POOL_MAX;
      endcase
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = rand64();
      if ($urandom_range(0, 2) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 2) == 0) key_pool[pool_n - 1] = '1;
      store_pct = $urandom_range(25, 60);
      take_pct  = $urandom_range(15, 35);
      for (int n = 0; n < SEG_WORDS; n++) begin
        key = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, pool_n - 1)];
        r   = $urandom_range(0, 99);
        if (r == 0) begin
          add_word(OP_CLEAR, key, 1'($urandom), rand64(), rand64(), rand64());
        end else if (r <= store_pct) begin
          add_word(OP_STORE, key, 1'($urandom), rand64(), rand64(), rand64());
        end else if (r <= store_pct + take_pct) begin
          add_word(OP_TAKE, key, 1'($urandom), rand64(), rand64(), rand64());
        end else begin
          add_word(OP_FIND, key, 1'($urandom), rand64(), rand64(), rand64());
        end
      end
    end
    total_words = pending_words.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt != total_words) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    // keep the clock running so a stray result word would still be caught
    repeat (12) @(posedge clk_i);

    if (errors == 0) begin
      $display("keyed_slot_table_find_or_allocate: match");
    end else begin
      $display("keyed_slot_table_find_or_allocate: mismatch");
    end
    $finish;
  end

endmodule

[keyed_slot_table_find_or_allocate.f]
+incdir+design
design/kst_pkg.sv
design/kst_ctrl.sv
design/kst_datapath.sv
design/keyed_slot_table_find_or_allocate.sv
verif/keyed_slot_table_find_or_allocate_test.sv
